[sv/vertex_project_to_screen_assert.svh]
// Assertion macros shared by the RTL of the vertex projection block.
// Each macro places one labeled concurrent assertion clocked by clk and
// disabled while arst_n is low.
`ifndef VERTEX_PROJECT_TO_SCREEN_ASSERT_SVH
`define VERTEX_PROJECT_TO_SCREEN_ASSERT_SVH

// Same-cycle implication.
`define VPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/vps_pkg.sv]
//------------------------------------------------------------------------------
// vps_pkg
// Types and constants of the vertex projection block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vps_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COORD_BITS = 32;
	// Projected sums: four products of 32x32 bits shifted down by FRAC_BITS.
	localparam int PROJ_W     = 2 * COORD_BITS - FRAC_BITS + 2;
	// Dividend of the fixed-point divide: magnitude followed by FRAC_BITS zeros.
	localparam int DIV_W      = PROJ_W + FRAC_BITS;
	localparam int QUO_W      = COORD_BITS + 1;
	localparam int DCNT_W     = $clog2(DIV_W);
	localparam int SCALE_W    = 14;
	localparam int MUL_W      = QUO_W + SCALE_W + 1;

	localparam int IN_DATA_W  = 4 + 5 * COORD_BITS;
	localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = 3 * COORD_BITS + 1;
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

	localparam logic [COORD_BITS-1:0] ONE_Q = COORD_BITS'(1) << FRAC_BITS;
	localparam logic [COORD_BITS-1:0] QMAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] QMIN  = {1'b1, {(COORD_BITS-1){1'b0}}};

	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_PROJECT = 1'b1;

	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_MIRROR_X      = 2'd2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DIV_INIT,
		ST_DIV,
		ST_RESOLVE,
		ST_MAP_MUL,
		ST_MAP_FIN,
		ST_DONE
	} state_t;

	// Reset content of a coefficient entry: the identity matrix.
	function automatic logic [COORD_BITS-1:0] identity_coef(input logic [3:0] idx);
		return (idx[1:0] == idx[3:2]) ? ONE_Q : '0;
	endfunction

endpackage

`default_nettype wire

[sv/vps_ram.sv]
//------------------------------------------------------------------------------
// vps_ram
// Generic single-write, single-read RAM with a registered read port.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[sv/vertex_project_to_screen.sv]
//------------------------------------------------------------------------------
// vertex_project_to_screen
// Perspective projection and viewport mapping of Q16.16 vertices through a
// 4x4 coefficient store.
//------------------------------------------------------------------------------
// Channel  | Dir | Beat contents
// s_axis   | in  | tuser = req_type; tdata = coef_index, coef_value, point x/y/z/w
// m_axis   | out | tuser = was_load; tdata = screen_x, screen_y, depth, range_error
// cfg      | in  | cfg_we, cfg_index, cfg_data; 0 width, 1 height, 2 mirror_x
//
// A load beat writes the coefficient on accept; the acknowledge then goes to
// the output register from the done state once that register is free.
// In a project beat the 16 multiply-accumulates stream through the
// coefficient RAM read port and two pipeline stages, then each of the three
// axes passes a setup step, the bit-serial divider, and the rounding (resolve)
// and viewport mapping (map multiply, map finish) steps; the done state then
// hands the result over.
// Reset loads the identity matrix through per-entry valid bits at once, so
// no clearing pass runs. The input stalls while a beat is being worked and
// while a finished result waits for the output register to free up; a result
// already in the output register does not block a new beat.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vertex_project_to_screen (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input stream
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [3:0] coef_index, [35:4] coef_value, [67:36] point_x, [99:68] point_y,
	// [131:100] point_z, [163:132] point_w, rest zero
	input  wire logic [vps_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// [0] req_type
	input  wire logic                             s_axis_tuser,
	// Output stream
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [31:0] screen_x, [63:32] screen_y, [95:64] depth, [96] range_error
	output logic      [vps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// [0] was_load
	output logic                                  m_axis_tuser,
	// Configuration
	input  wire logic                             cfg_we,
	input  wire logic [1:0]                       cfg_index,
	input  wire logic [vps_pkg::SCALE_W-1:0]      cfg_data
);

	import vps_pkg::*;

	localparam int CW = COORD_BITS;

	// Configuration registers.
	logic [SCALE_W-1:0] width_q, height_q;
	logic               mirror_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SCALE_W'(640);
			height_q <= SCALE_W'(480);
			mirror_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:  width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: height_q <= cfg_data;
				CFG_MIRROR_X:      mirror_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input beat fields.
	logic [3:0]    in_index;
	logic [CW-1:0] in_coef;
	logic [CW-1:0] in_pt [4];
	logic          in_acc;

	assign in_index = s_axis_tdata[3:0];
	assign in_coef  = s_axis_tdata[4 +: CW];
	for (genvar g = 0; g < 4; g++) begin : g_pt
		assign in_pt[g] = s_axis_tdata[4 + CW*(g+1) +: CW];
	end
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// Control state.
	state_t              state_q, state_d;
	logic [4:0]          mac_cnt_q;
	logic                rd_vld_s1, mul_vld_s2;
	logic [3:0]          idx_s1, idx_s2;
	logic [1:0]          axis_q;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic                err_q, load_q;
	logic [15:0]         coef_vld_q;
	logic                out_valid_q;

	// Datapath registers.
	logic [CW-1:0]              pt_q [4];
	logic                       coef_vld_s1;
	logic signed [2*CW-1:0]     prod_s2;
	logic signed [PROJ_W-1:0]   acc_q;
	logic signed [PROJ_W-1:0]   proj_q [4];
	logic [DIV_W-1:0]           num_sh_q;
	logic [PROJ_W-1:0]          den_q;
	logic [PROJ_W-1:0]          rem_q;
	logic [QUO_W-1:0]           quo_q;
	logic                       big_q, neg_q, npos_q, nneg_q, dzero_q;
	logic [CW-1:0]              q_q;
	logic signed [MUL_W-1:0]    map_q;
	logic [CW-1:0]              res_q [3];
	logic [OUT_TDATA_W-1:0]     out_data_q;
	logic                       out_user_q;

	// Control strobes.
	logic ram_we, mac_issue, mac_last, div_last, out_load;

	always_comb begin
		ram_we    = 1'b0;
		mac_issue = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: ram_we    = in_acc && (s_axis_tuser == REQ_LOAD);
			ST_MAC:  mac_issue = !mac_cnt_q[4];
			ST_DONE: out_load  = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign mac_last = mul_vld_s2 && (idx_s2 == 4'd15);
	assign div_last = (div_cnt_q == DCNT_W'(DIV_W - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (s_axis_tuser == REQ_PROJECT) ? ST_MAC : ST_DONE;
				end
			end
			ST_MAC:      if (mac_last) state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV:      if (div_last) state_d = ST_RESOLVE;
			ST_RESOLVE:  state_d = ST_MAP_MUL;
			ST_MAP_MUL:  state_d = ST_MAP_FIN;
			ST_MAP_FIN:  state_d = (axis_q == AXIS_Z) ? ST_DONE : ST_DIV_INIT;
			ST_DONE:     if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	// Coefficient store. The sequence counter is {column, row}; the entry
	// address is row * 4 + column.
	logic [3:0]    ram_raddr;
	logic [CW-1:0] ram_rdata;

	assign ram_raddr = {mac_cnt_q[1:0], mac_cnt_q[3:2]};

	vps_ram #(
		.WIDTH(CW),
		.DEPTH(16)
	) u_coef_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(in_index),
		.wdata(in_coef),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Multiply-accumulate datapath.
	logic [CW-1:0]            coef_s1;
	logic signed [PROJ_W-1:0] term, acc_next;

	assign coef_s1 = coef_vld_s1 ? ram_rdata : identity_coef({idx_s1[1:0], idx_s1[3:2]});
	// Floor shift of the exact product, sign-extended to the sum width.
	assign term     = PROJ_W'(prod_s2 >>> FRAC_BITS);
	assign acc_next = ((idx_s2[1:0] == 2'd0) ? '0 : acc_q) + term;

	// Divider setup.
	logic signed [PROJ_W-1:0] num_sel, den_sel;
	logic [PROJ_W-1:0]        n_abs, d_abs;

	assign num_sel = proj_q[axis_q];
	assign den_sel = proj_q[3];
	assign n_abs   = num_sel[PROJ_W-1] ? (~num_sel + 1'b1) : num_sel;
	assign d_abs   = den_sel[PROJ_W-1] ? (~den_sel + 1'b1) : den_sel;

	// One restoring divide step.
	logic [PROJ_W:0] rem_try;
	logic            q_bit;

	assign rem_try = {rem_q, num_sh_q[DIV_W-1]};
	assign q_bit   = (rem_try >= {1'b0, den_q});

	// Rounding of the quotient to a saturated coordinate.
	logic [QUO_W-1:0] lim;
	logic             sat_div;
	logic [CW-1:0]    q_res;
	logic [CW-1:0]    quo_neg;

	assign lim     = neg_q ? {1'b0, QMIN} : {1'b0, QMAX};
	assign sat_div = big_q || (quo_q > lim);
	assign quo_neg = ~quo_q[CW-1:0] + 1'b1;

	always_comb begin
		priority if (dzero_q) begin
			q_res = npos_q ? QMAX : (nneg_q ? QMIN : '0);
		end else if (sat_div) begin
			q_res = neg_q ? QMIN : QMAX;
		end else begin
			q_res = neg_q ? quo_neg : quo_q[CW-1:0];
		end
	end

	// Viewport mapping.
	logic [SCALE_W-1:0]       scale_sel;
	logic                     flip;
	logic signed [QUO_W-1:0]  q_plus;
	logic signed [MUL_W-1:0]  mul_res;
	logic signed [MUL_W:0]    half, base, mapped;
	logic                     ovf;
	logic [CW-1:0]            final_val;

	always_comb begin
		unique case (axis_q)
			AXIS_X:  begin scale_sel = width_q;        flip = mirror_q; end
			AXIS_Y:  begin scale_sel = height_q;       flip = 1'b1;     end
			default: begin scale_sel = SCALE_W'(1);    flip = 1'b0;     end
		endcase
	end

	assign q_plus  = $signed({q_q[CW-1], q_q}) + $signed({1'b0, ONE_Q});
	assign mul_res = q_plus * $signed({1'b0, scale_sel});
	assign half    = $signed({map_q[MUL_W-1], map_q}) >>> 1;
	assign base    = $signed({{(MUL_W+1-SCALE_W-FRAC_BITS){1'b0}}, scale_sel,
		{FRAC_BITS{1'b0}}});
	assign mapped  = flip ? (base - half) : half;
	assign ovf     = !((mapped[MUL_W:CW-1] == '0) || (mapped[MUL_W:CW-1] == '1));
	assign final_val = ovf ? (mapped[MUL_W] ? QMIN : QMAX) : mapped[CW-1:0];

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mac_cnt_q   <= '0;
			rd_vld_s1   <= 1'b0;
			mul_vld_s2  <= 1'b0;
			idx_s1      <= '0;
			idx_s2      <= '0;
			axis_q      <= AXIS_X;
			div_cnt_q   <= '0;
			err_q       <= 1'b0;
			load_q      <= 1'b0;
			coef_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_vld_s1  <= mac_issue;
			idx_s1     <= mac_cnt_q[3:0];
			mul_vld_s2 <= rd_vld_s1;
			idx_s2     <= idx_s1;
			if (ram_we) begin
				coef_vld_q[in_index] <= 1'b1;
			end
			if (in_acc) begin
				mac_cnt_q <= '0;
				axis_q    <= AXIS_X;
				err_q     <= 1'b0;
				load_q    <= (s_axis_tuser == REQ_LOAD);
			end else if (mac_issue) begin
				mac_cnt_q <= mac_cnt_q + 1'b1;
			end
			if (state_q == ST_DIV_INIT) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (state_q == ST_RESOLVE) begin
				err_q <= err_q || dzero_q || sat_div;
			end
			if (state_q == ST_MAP_FIN) begin
				err_q  <= err_q || ovf;
				axis_q <= axis_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pt_q <= in_pt;
		end
		coef_vld_s1 <= coef_vld_q[ram_raddr];
		prod_s2     <= $signed(pt_q[idx_s1[1:0]]) * $signed(coef_s1);
		if (mul_vld_s2) begin
			acc_q <= acc_next;
			if (idx_s2[1:0] == 2'd3) begin
				proj_q[idx_s2[3:2]] <= acc_next;
			end
		end
		if (state_q == ST_DIV_INIT) begin
			num_sh_q <= {n_abs, {FRAC_BITS{1'b0}}};
			den_q    <= d_abs;
			rem_q    <= '0;
			quo_q    <= '0;
			big_q    <= 1'b0;
			neg_q    <= num_sel[PROJ_W-1] != den_sel[PROJ_W-1];
			npos_q   <= !num_sel[PROJ_W-1] && (num_sel != '0);
			nneg_q   <= num_sel[PROJ_W-1];
			dzero_q  <= (d_abs == '0);
		end
		if (state_q == ST_DIV) begin
			rem_q    <= q_bit ? PROJ_W'(rem_try - {1'b0, den_q}) : rem_try[PROJ_W-1:0];
			num_sh_q <= {num_sh_q[DIV_W-2:0], 1'b0};
			quo_q    <= {quo_q[QUO_W-2:0], q_bit};
			big_q    <= big_q || quo_q[QUO_W-1];
		end
		if (state_q == ST_RESOLVE) begin
			q_q <= q_res;
		end
		if (state_q == ST_MAP_MUL) begin
			map_q <= mul_res;
		end
		if (state_q == ST_MAP_FIN) begin
			res_q[axis_q] <= final_val;
		end
		if (out_load) begin
			out_user_q <= load_q;
			out_data_q <= load_q ? '0 :
				OUT_TDATA_W'({err_q, res_q[2], res_q[1], res_q[0]});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	`include "vertex_project_to_screen_assert.svh"

	`VPS_ASSERT_NOW(a_load_only_idle, ram_we, state_q == ST_IDLE, "coefficient write outside idle")
	`VPS_ASSERT_NOW(a_out_slot_free, out_load, !out_valid_q || m_axis_tready, "result overwrites pending beat")
	`VPS_ASSERT_NOW(a_div_count, state_q == ST_DIV, div_cnt_q <= DCNT_W'(DIV_W - 1), "divide step count overrun")
	`VPS_ASSERT_NEXT(a_load_ack, in_acc && (s_axis_tuser == REQ_LOAD), state_q == ST_DONE && load_q, "load not acknowledged")

endmodule

`default_nettype wire
